@@ design/spmt_pkg.sv @@
// Shared types, constants and a helper function for the slot paging MMU.
package spmt_pkg;

  localparam int SLOT_COUNT       = 8;
  localparam int SLOT_IDX_W       = $clog2(SLOT_COUNT);
  localparam int SLOT_OFFSET_BITS = 13;
  localparam int ADDR_W           = SLOT_IDX_W + SLOT_OFFSET_BITS;
  localparam int PAGE_W           = 8;
  localparam int BANK_W           = 2;
  localparam int PHYS_W           = 21;
  localparam int CFG_ADDR_W       = 4;
  localparam int CFG_DATA_W       = 32;
  localparam int PORT_W           = 8;
  localparam int PORT_BANK_BIT    = 2;

  localparam logic [PAGE_W-1:0] ROM_PAGE  = 8'hFF;
  localparam logic [PAGE_W-1:0] RAM_PAGES = 8'd224;

  localparam logic [1:0] REG_ALT_ROM_ENABLE      = 2'd0;
  localparam logic [1:0] REG_ALT_ROM_WRITES_ONLY = 2'd1;
  localparam logic [1:0] REG_RAM_AVAILABLE       = 2'd2;

  typedef enum logic [1:0] {
    MODE_SET_PAGE    = 2'd0,
    MODE_LATCH_BANK  = 2'd1,
    MODE_TRANSLATE   = 2'd2,
    MODE_DEFAULT_MAP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REGION_MAIN_ROM = 2'd0,
    REGION_ALT_ROM  = 2'd1,
    REGION_RAM      = 2'd2
  } region_t;

  typedef struct packed {
    logic alt_rom_enable;
    logic alt_rom_writes_only;
    logic ram_available;
  } cfg_t;

  typedef struct packed {
    mode_t                       mode;
    logic [SLOT_IDX_W-1:0]       slot_idx;
    logic [PAGE_W-1:0]           page;
    logic [SLOT_OFFSET_BITS-1:0] offset;
  } item_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_idx;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
    logic [PAGE_W-1:0]     wr_data;
    logic                  restore;
  } mem_req_t;

  function automatic logic [PAGE_W-1:0] default_page(input logic [SLOT_IDX_W-1:0] idx);
    logic [PAGE_W-1:0] pg;
    case (idx)
      3'd0:    pg = ROM_PAGE;
      3'd1:    pg = ROM_PAGE;
      3'd2:    pg = 8'd10;
      3'd3:    pg = 8'd11;
      3'd4:    pg = 8'd4;
      3'd5:    pg = 8'd5;
      3'd6:    pg = 8'd0;
      3'd7:    pg = 8'd1;
      default: pg = ROM_PAGE;
    endcase
    return pg;
  endfunction

endpackage

@@ design/spmt_if.sv @@
// Valid/ready channel interfaces for the request and result transactions.
interface spmt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             mode;
  logic [spmt_pkg::SLOT_IDX_W-1:0]        slot;
  logic [spmt_pkg::PAGE_W-1:0]            page;
  logic                                   rom_latch_bit;
  logic [spmt_pkg::PORT_W-1:0]            port_1ffd_value;
  logic [spmt_pkg::ADDR_W-1:0]            cpu_address;

  modport source (output valid, mode, slot, page, rom_latch_bit, port_1ffd_value,
                  cpu_address, input ready);
  modport sink (input valid, mode, slot, page, rom_latch_bit, port_1ffd_value,
                cpu_address, output ready);
endinterface

interface spmt_out_if;
  logic                          valid;
  logic                          ready;
  spmt_pkg::region_t             region;
  logic [spmt_pkg::PHYS_W-1:0]   phys_offset;
  logic                          read_only;
  logic [spmt_pkg::PAGE_W-1:0]   slot_page;
  logic [spmt_pkg::BANK_W-1:0]   current_rom_bank;

  modport source (output valid, region, phys_offset, read_only, slot_page,
                  current_rom_bank, input ready);
  modport sink (input valid, region, phys_offset, read_only, slot_page,
                current_rom_bank, output ready);
endinterface

@@ design/spmt_page_mem.sv @@
// Page register memory with registered read data and per-slot valid bits for the default map.
module spmt_page_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spmt_pkg::mem_req_t              req,
  output logic [spmt_pkg::PAGE_W-1:0]     rd_page
);

  logic [spmt_pkg::PAGE_W-1:0]     mem_r [spmt_pkg::SLOT_COUNT];
  logic [spmt_pkg::SLOT_COUNT-1:0] vld_r;
  logic [spmt_pkg::SLOT_COUNT-1:0] vld_nxt;
  logic [spmt_pkg::PAGE_W-1:0]     rd_data_r;
  logic [spmt_pkg::SLOT_IDX_W-1:0] rd_idx_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_idx];
      rd_idx_r  <= req.rd_idx;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (req.restore) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_idx];
      end
    end
  end

  // An entry not written since reset or the last default map reads as its default page.
  assign rd_page = rd_vld_r ? rd_data_r : spmt_pkg::default_page(rd_idx_r);

endmodule

@@ design/spmt_cfg_regs.sv @@
// APB-style configuration registers for the alternate ROM and RAM presence.
module spmt_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spmt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [spmt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [spmt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output spmt_pkg::cfg_t                    cfg
);

  spmt_pkg::cfg_t cfg_r;
  spmt_pkg::cfg_t cfg_nxt;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        spmt_pkg::REG_ALT_ROM_ENABLE:      cfg_nxt.alt_rom_enable      = pwdata[0];
        spmt_pkg::REG_ALT_ROM_WRITES_ONLY: cfg_nxt.alt_rom_writes_only = pwdata[0];
        spmt_pkg::REG_RAM_AVAILABLE:       cfg_nxt.ram_available       = pwdata[0];
        default:                           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alt_rom_enable      <= 1'b0;
      cfg_r.alt_rom_writes_only <= 1'b0;
      cfg_r.ram_available       <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      spmt_pkg::REG_ALT_ROM_ENABLE:      prdata[0] = cfg_r.alt_rom_enable;
      spmt_pkg::REG_ALT_ROM_WRITES_ONLY: prdata[0] = cfg_r.alt_rom_writes_only;
      spmt_pkg::REG_RAM_AVAILABLE:       prdata[0] = cfg_r.ram_available;
      default:                           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ design/spmt_xlate.sv @@
// Translation stage that combines the read page with the item and holds the result register.
module spmt_xlate #(
  parameter logic [spmt_pkg::PAGE_W-1:0] RAM_PAGES = spmt_pkg::RAM_PAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_acc,
  input  spmt_pkg::item_t               item,
  input  spmt_pkg::cfg_t                cfg,
  input  logic [spmt_pkg::BANK_W-1:0]   bank,
  input  logic [spmt_pkg::PAGE_W-1:0]   rd_page,
  output logic                          stg_free,
  spmt_out_if.source                    out_ch
);

  logic                          stg_vld_r;
  logic                          stg_vld_nxt;
  spmt_pkg::item_t               stg_item_r;
  logic                          stg_adv;

  logic                          out_vld_r;
  logic                          out_vld_nxt;
  spmt_pkg::region_t             region_r;
  logic [spmt_pkg::PHYS_W-1:0]   phys_r;
  logic                          ro_r;
  logic [spmt_pkg::PAGE_W-1:0]   pg_r;
  logic [spmt_pkg::BANK_W-1:0]   bank_out_r;

  logic [spmt_pkg::PAGE_W-1:0]   page_now;
  logic                          is_ram;
  logic                          low_slot;
  spmt_pkg::region_t             region_nxt;
  logic [spmt_pkg::PHYS_W-1:0]   phys_nxt;
  logic                          ro_nxt;

  assign stg_adv  = stg_vld_r && (!out_vld_r || out_ch.ready);
  assign stg_free = !stg_vld_r || stg_adv;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (stg_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_item_r <= item;
    end
  end

  always_comb begin
    case (stg_item_r.mode)
      spmt_pkg::MODE_SET_PAGE:    page_now = stg_item_r.page;
      spmt_pkg::MODE_DEFAULT_MAP: page_now = spmt_pkg::default_page(stg_item_r.slot_idx);
      default:                    page_now = rd_page;
    endcase
  end

  assign is_ram   = (page_now != spmt_pkg::ROM_PAGE) && (page_now < RAM_PAGES) &&
                    cfg.ram_available;
  assign low_slot = (stg_item_r.slot_idx[spmt_pkg::SLOT_IDX_W-1:1] == '0);

  always_comb begin
    region_nxt = spmt_pkg::REGION_MAIN_ROM;
    phys_nxt   = '0;
    ro_nxt     = 1'b0;
    if (stg_item_r.mode == spmt_pkg::MODE_TRANSLATE) begin
      ro_nxt = 1'b1;
      if (is_ram) begin
        region_nxt = spmt_pkg::REGION_RAM;
        phys_nxt   = spmt_pkg::PHYS_W'({page_now, stg_item_r.offset});
        ro_nxt     = 1'b0;
      end else if (low_slot) begin
        if (cfg.alt_rom_enable && !cfg.alt_rom_writes_only) begin
          region_nxt = spmt_pkg::REGION_ALT_ROM;
          phys_nxt   = spmt_pkg::PHYS_W'({bank[0], stg_item_r.slot_idx[0],
                                          stg_item_r.offset});
        end else begin
          phys_nxt = spmt_pkg::PHYS_W'({bank, stg_item_r.slot_idx[0], stg_item_r.offset});
        end
      end else begin
        phys_nxt = spmt_pkg::PHYS_W'({stg_item_r.slot_idx, stg_item_r.offset});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      region_r   <= region_nxt;
      phys_r     <= phys_nxt;
      ro_r       <= ro_nxt;
      pg_r       <= page_now;
      bank_out_r <= bank;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.region           = region_r;
  assign out_ch.phys_offset      = phys_r;
  assign out_ch.read_only        = ro_r;
  assign out_ch.slot_page        = pg_r;
  assign out_ch.current_rom_bank = bank_out_r;

endmodule

@@ design/slot_page_mmu_translate.sv @@
// Top level of the 8 KB slot paging MMU: page memory, ROM bank and translation stage.
//
//   Channel   Direction  Handshake                  Carries
//   in_ch     sink       valid/ready                mode, slot, page, bank bits, address
//   out_ch    source     valid/ready                region, offset, read_only, page, bank
//   APB       slave      psel/penable, pready = 1   three one-bit configuration registers
//
// One transaction is accepted per cycle while input ready is high; it is registered in the
// translation stage and its result is registered into the output when the stage advances.
// The page memory is read at acceptance and its registered data is used by the stage. Page
// writes, default map and bank latch take effect at acceptance, so the next transaction's
// read already sees them. Reset loads the default map with no clearing pass. A stalled
// result holds the stage; input ready drops only when both stage and output are full.
module slot_page_mmu_translate #(
  parameter logic [spmt_pkg::PAGE_W-1:0] RAM_PAGES = spmt_pkg::RAM_PAGES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  spmt_in_if.sink                           in_ch,
  spmt_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spmt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [spmt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [spmt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  spmt_pkg::cfg_t                  cfg;
  spmt_pkg::item_t                 item;
  spmt_pkg::mem_req_t              mem_req;
  logic [spmt_pkg::PAGE_W-1:0]     rd_page;
  logic [spmt_pkg::BANK_W-1:0]     bank_r;
  logic [spmt_pkg::BANK_W-1:0]     bank_nxt;
  logic                            stg_free;
  logic                            in_acc;

  assign in_ch.ready = stg_free;
  assign in_acc      = in_ch.valid && stg_free;

  always_comb begin
    item.mode     = spmt_pkg::mode_t'(in_ch.mode);
    item.slot_idx = (item.mode == spmt_pkg::MODE_TRANSLATE) ?
                    in_ch.cpu_address[spmt_pkg::ADDR_W-1:spmt_pkg::SLOT_OFFSET_BITS] :
                    in_ch.slot;
    item.page     = in_ch.page;
    item.offset   = in_ch.cpu_address[spmt_pkg::SLOT_OFFSET_BITS-1:0];
  end

  always_comb begin
    mem_req.rd_en   = in_acc;
    mem_req.rd_idx  = item.slot_idx;
    mem_req.wr_en   = in_acc && (item.mode == spmt_pkg::MODE_SET_PAGE);
    mem_req.wr_idx  = in_ch.slot;
    mem_req.wr_data = in_ch.page;
    mem_req.restore = in_acc && (item.mode == spmt_pkg::MODE_DEFAULT_MAP);
  end

  always_comb begin
    bank_nxt = bank_r;
    if (in_acc) begin
      case (item.mode)
        spmt_pkg::MODE_LATCH_BANK:  bank_nxt = {in_ch.port_1ffd_value[spmt_pkg::PORT_BANK_BIT],
                                                in_ch.rom_latch_bit};
        spmt_pkg::MODE_DEFAULT_MAP: bank_nxt = '0;
        default:                    bank_nxt = bank_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  spmt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spmt_page_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_page (rd_page)
  );

  spmt_xlate #(
    .RAM_PAGES (RAM_PAGES)
  ) u_xlate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .item     (item),
    .cfg      (cfg),
    .bank     (bank_r),
    .rd_page  (rd_page),
    .stg_free (stg_free),
    .out_ch   (out_ch)
  );

endmodule

@@ design/spmt_checker.sv @@
// Port-level checker for the slot paging MMU and its bind to the top level.
module spmt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_region,
  input logic [spmt_pkg::PHYS_W-1:0]       out_phys_offset,
  input logic [spmt_pkg::PAGE_W-1:0]       out_slot_page,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready,
  input logic [spmt_pkg::CFG_ADDR_W-1:0]   paddr,
  input logic [spmt_pkg::CFG_DATA_W-1:0]   pwdata,
  input logic [spmt_pkg::CFG_DATA_W-1:0]   prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_region) &&
    $stable(out_phys_offset) && $stable(out_slot_page))
    else $error("Stalled result transaction changed.");

  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input ready dropped while the result side was free.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("Accepted transaction produced no result.");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[3:2] == spmt_pkg::REG_RAM_AVAILABLE) ##1
    (psel && !pwrite && paddr[3:2] == spmt_pkg::REG_RAM_AVAILABLE)
    |-> prdata[0] == $past(pwdata[0]))
    else $error("Configuration register read back a stale value.");

endmodule

bind slot_page_mmu_translate spmt_checker u_spmt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_region      (out_ch.region),
  .out_phys_offset (out_ch.phys_offset),
  .out_slot_page   (out_ch.slot_page),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);

@@ tb/tb_top.sv @@
// Self-checking testbench that drives directed and random paging requests and checks each result.
module tb_top;
  import spmt_pkg::*;

  typedef struct {
    mode_t                 mode;
    logic [SLOT_IDX_W-1:0] slot;
    logic [PAGE_W-1:0]     page;
    logic                  latch;
    logic [PORT_W-1:0]     port;
    logic [ADDR_W-1:0]     addr;
  } mmu_request_t;

  typedef struct {
    region_t           region;
    logic [PHYS_W-1:0] phys;
    logic              ro;
    logic [PAGE_W-1:0] page;
    logic [BANK_W-1:0] bank;
  } mmu_result_t;

  class translation_scoreboard;
    logic [PAGE_W-1:0] slot_pages [SLOT_COUNT];
    logic [BANK_W-1:0] bank_index;
    cfg_t              cfg;
    mmu_result_t       pending_results[$];
    int                errors;

    function new();
      cfg.alt_rom_enable      = 1'b0;
      cfg.alt_rom_writes_only = 1'b0;
      cfg.ram_available       = 1'b1;
      errors = 0;
      load_default_map();
    endfunction

    function void load_default_map();
      slot_pages = '{ROM_PAGE, ROM_PAGE, 8'd10, 8'd11, 8'd4, 8'd5, 8'd0, 8'd1};
      bank_index = '0;
    endfunction

    function void set_config(logic [1:0] idx, logic val);
      case (idx)
        REG_ALT_ROM_ENABLE:      cfg.alt_rom_enable = val;
        REG_ALT_ROM_WRITES_ONLY: cfg.alt_rom_writes_only = val;
        REG_RAM_AVAILABLE:       cfg.ram_available = val;
        default: ;
      endcase
    endfunction

    function void note_request(mmu_request_t req);
      mmu_result_t                 res;
      logic [SLOT_IDX_W-1:0]       s;
      logic [SLOT_OFFSET_BITS-1:0] off;
      logic [PAGE_W-1:0]           pg;
      logic [PHYS_W-1:0]           slot_base;
      res.region = REGION_MAIN_ROM;
      res.phys   = '0;
      res.ro     = 1'b0;
      if (req.mode == MODE_TRANSLATE) begin
        s = req.addr[ADDR_W-1:SLOT_OFFSET_BITS];
        off = req.addr[SLOT_OFFSET_BITS-1:0];
        pg = slot_pages[s];
        slot_base = PHYS_W'(s) << SLOT_OFFSET_BITS;
        res.page = pg;
        res.ro = 1'b1;
        if (pg != ROM_PAGE && pg < RAM_PAGES && cfg.ram_available) begin
          res.region = REGION_RAM;
          res.phys = (PHYS_W'(pg) << SLOT_OFFSET_BITS) + PHYS_W'(off);
          res.ro = 1'b0;
        end else if (s < 2) begin
          if (cfg.alt_rom_enable && !cfg.alt_rom_writes_only) begin
            res.region = REGION_ALT_ROM;
            res.phys = (PHYS_W'(bank_index[0]) << (SLOT_OFFSET_BITS + 1)) + slot_base
                       + PHYS_W'(off);
          end else begin
            res.phys = (PHYS_W'(bank_index) << (SLOT_OFFSET_BITS + 1)) + slot_base
                       + PHYS_W'(off);
          end
        end else begin
          res.phys = slot_base + PHYS_W'(off);
        end
      end else begin
        case (req.mode)
          MODE_SET_PAGE:   slot_pages[req.slot] = req.page;
          MODE_LATCH_BANK: bank_index = {req.port[PORT_BANK_BIT], req.latch};
          default:         load_default_map();
        endcase
        res.page = slot_pages[req.slot];
      end
      res.bank = bank_index;
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(mmu_result_t got);
      mmu_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result transaction region=%0d offset=%h",
                         got.region, got.phys));
        return;
      end
      want = pending_results.pop_front();
      if (got.region !== want.region)
        report($sformatf("region got %0d want %0d", got.region, want.region));
      if (got.phys !== want.phys)
        report($sformatf("phys_offset got %h want %h", got.phys, want.phys));
      if (got.ro !== want.ro)
        report($sformatf("read_only got %b want %b", got.ro, want.ro));
      if (got.page !== want.page)
        report($sformatf("slot_page got %h want %h", got.page, want.page));
      if (got.bank !== want.bank)
        report($sformatf("current_rom_bank got %0d want %0d", got.bank, want.bank));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    no_idle;

  translation_scoreboard sb = new();

  spmt_in_if  in_ch();
  spmt_out_if out_ch();

  slot_page_mmu_translate i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic mmu_request_t random_fill();
    mmu_request_t r;
    r.mode  = MODE_TRANSLATE;
    r.slot  = SLOT_IDX_W'($urandom);
    r.page  = PAGE_W'($urandom);
    r.latch = 1'($urandom);
    r.port  = PORT_W'($urandom);
    r.addr  = ADDR_W'($urandom);
    return r;
  endfunction

  function automatic mmu_request_t random_request();
    mmu_request_t r;
    int           pick;
    int           kind;
    r = random_fill();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 3) == 0)
        r.addr[ADDR_W-1:ADDR_W-2] = 2'b00;
    end else if (pick < 80) begin
      r.mode = MODE_SET_PAGE;
      kind = $urandom_range(0, 99);
      if (kind < 40)
        r.page = PAGE_W'($urandom_range(0, RAM_PAGES - 1));
      else if (kind < 60)
        r.page = PAGE_W'($urandom_range(RAM_PAGES, ROM_PAGE - 1));
      else if (kind < 85)
        r.page = ROM_PAGE;
    end else if (pick < 92) begin
      r.mode = MODE_LATCH_BANK;
    end else begin
      r.mode = MODE_DEFAULT_MAP;
    end
    return r;
  endfunction

  task automatic send_item(mmu_request_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= r.mode;
    in_ch.slot            <= r.slot;
    in_ch.page            <= r.page;
    in_ch.rom_latch_bit   <= r.latch;
    in_ch.port_1ffd_value <= r.port;
    in_ch.cpu_address     <= r.addr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  task automatic do_translate(logic [ADDR_W-1:0] addr);
    mmu_request_t r;
    r = random_fill();
    r.addr = addr;
    send_item(r);
  endtask

  task automatic do_set_page(logic [SLOT_IDX_W-1:0] slot, logic [PAGE_W-1:0] page);
    mmu_request_t r;
    r = random_fill();
    r.mode = MODE_SET_PAGE;
    r.slot = slot;
    r.page = page;
    send_item(r);
  endtask

  task automatic do_latch(logic latch, logic [PORT_W-1:0] port);
    mmu_request_t r;
    r = random_fill();
    r.mode = MODE_LATCH_BANK;
    r.latch = latch;
    r.port = port;
    send_item(r);
  endtask

  task automatic do_default_map(logic [SLOT_IDX_W-1:0] slot);
    mmu_request_t r;
    r = random_fill();
    r.mode = MODE_DEFAULT_MAP;
    r.slot = slot;
    send_item(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_config(idx, val);
    @(posedge clk);
  endtask

  initial begin
    mmu_result_t got;
    int          stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.region = out_ch.region;
      got.phys   = out_ch.phys_offset;
      got.ro     = out_ch.read_only;
      got.page   = out_ch.slot_page;
      got.bank   = out_ch.current_rom_bank;
      sb.check_result(got);
    end
  end

  initial begin
    logic [2:0] setting;
    no_idle               = 1'b0;
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= MODE_TRANSLATE;
    in_ch.slot            <= '0;
    in_ch.page            <= '0;
    in_ch.rom_latch_bit   <= 1'b0;
    in_ch.port_1ffd_value <= '0;
    in_ch.cpu_address     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    do_translate(16'h0000);
    do_translate(16'h3FFF);
    do_translate(16'hFFFF);
    do_translate(16'h4000);
    do_latch(1'b1, 8'hFF);
    do_translate(16'h2ABC);
    do_latch(1'b0, 8'h04);
    do_translate(16'h1234);
    do_latch(1'b1, 8'hFB);
    do_translate(16'h3000);
    do_set_page(3'd0, 8'd0);
    do_translate(16'h1FFF);
    do_set_page(3'd1, PAGE_W'(RAM_PAGES - 1));
    do_translate(16'h3FFF);
    do_set_page(3'd3, RAM_PAGES);
    do_translate(16'h7FFF);
    do_set_page(3'd7, ROM_PAGE);
    do_translate(16'hE000);
    do_set_page(3'd5, PAGE_W'(ROM_PAGE - 1));
    do_translate(16'hA000);
    do_default_map(3'd7);
    do_translate(16'hFFFF);
    do_translate(16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      setting = 3'(ph) ^ 3'b001;
      apb_write(REG_ALT_ROM_ENABLE, setting[2]);
      apb_write(REG_ALT_ROM_WRITES_ONLY, setting[1]);
      apb_write(REG_RAM_AVAILABLE, setting[0]);
      do_translate(16'h0000);
      do_translate(16'h2000);
      for (int i = 0; i < 168; i++) begin
        no_idle = (i < 30);
        if (i == 90)
          drain();
        send_item(random_request());
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("slot_page_mmu_translate: match");
    end else begin
      $display("slot_page_mmu_translate: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("slot_page_mmu_translate: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
design/spmt_pkg.sv
design/spmt_if.sv
design/spmt_page_mem.sv
design/spmt_cfg_regs.sv
design/spmt_xlate.sv
design/slot_page_mmu_translate.sv
design/spmt_checker.sv
tb/tb_top.sv
